@@ hdl/mts_pkg.sv @@
`timescale 1ns / 1ps

package mts_pkg;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned FillW = 9;

  // one stack entry: held value and the minimum of it and everything below
  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic signed [DataW-1:0] mn;
  } entry_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

@@ hdl/min_tracking_stack.sv @@
`timescale 1ns / 1ps

// Min-tracking stack: a bounded stack of signed 32-bit values built as a row
// of STACK_DEPTH shift cells, with the top entry always held in the first
// cell. Each cell keeps its value and the minimum of that value and all
// values below it, so the current minimum sits beside the top. Every request
// (push or pop) is one item and produces one result item in the next cycle
// with the status, new top, current minimum, empty flag and fill count.
// One item is taken per clock cycle while the result register is free or
// its item is taken; a push or pop moves the whole row of cells by one
// place, and the result register frees whenever its item is taken. Pop on
// empty is ignored (status 1), push on full is dropped (status 2); top and
// minimum read 0 when empty; fill_count shows the low 9 bits of the count.
module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic signed [mts_pkg::DataW-1:0] push_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic signed [mts_pkg::DataW-1:0] top_value_o,
  output logic signed [mts_pkg::DataW-1:0] min_value_o,
  output logic        is_empty_o,
  output logic [mts_pkg::FillW-1:0] fill_count_o
);
  import mts_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  logic            accept;
  logic            is_full, is_zero;
  logic            do_push, do_pop;
  status_e         status_res;
  shift_ctrl_t     ctrl;
  entry_t          new_entry;
  entry_t          res_entry;
  entry_t          cell_out [STACK_DEPTH];
  logic [CntW-1:0] count_d, count_q;

  logic            out_valid_d, out_valid_q;
  status_e         status_d, status_q;
  entry_t          res_d, res_q;
  logic            empty_d, empty_q;
  logic [CntW-1:0] fill_q;

  // handshake: take an item whenever the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_full = (count_q == CntW'(STACK_DEPTH));
  assign is_zero = (count_q == '0);

  // request decode
  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    status_res = ST_OK;
    if (req_type_i == REQ_PUSH) begin
      if (is_full) begin
        status_res = ST_PUSH_FULL;
      end else begin
        do_push = accept;
      end
    end else begin
      if (is_zero) begin
        status_res = ST_POP_EMPTY;
      end else begin
        do_pop = accept;
      end
    end
  end

  assign ctrl.push = do_push;
  assign ctrl.pop  = do_pop;

  // new top entry with its running minimum
  always_comb begin
    new_entry.val = push_value_i;
    if (is_zero || (push_value_i <= cell_out[0].mn)) begin
      new_entry.mn = push_value_i;
    end else begin
      new_entry.mn = cell_out[0].mn;
    end
  end

  // entry count
  always_comb begin
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  // row of cells, top first
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t up_e, dn_e;
    if (i == 0) begin : g_top
      assign up_e = new_entry;
    end else begin : g_mid
      assign up_e = cell_out[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign dn_e = cell_out[i];
    end else begin : g_inner
      assign dn_e = cell_out[i+1];
    end
    mts_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .up_i    (up_e),
      .dn_i    (dn_e),
      .entry_o (cell_out[i])
    );
  end

  // top after the request
  always_comb begin
    if (do_push) begin
      res_entry = new_entry;
    end else if (do_pop) begin
      res_entry = cell_out[1];
    end else begin
      res_entry = cell_out[0];
    end
  end

  // result register next values
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    res_d       = res_q;
    empty_d     = empty_q;
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = status_res;
      empty_d     = (count_d == '0);
      res_d       = (count_d == '0) ? '0 : res_entry;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    res_q    <= res_d;
    empty_q  <= empty_d;
    if (accept) begin
      fill_q <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign top_value_o  = res_q.val;
  assign min_value_o  = res_q.mn;
  assign is_empty_o   = empty_q;
  assign fill_count_o = FillW'(fill_q);

endmodule

@@ hdl/mts_cell.sv @@
`timescale 1ns / 1ps

module mts_cell (
  input  logic                clk_i,
  input  mts_pkg::shift_ctrl_t ctrl_i,
  input  mts_pkg::entry_t     up_i,
  input  mts_pkg::entry_t     dn_i,
  output mts_pkg::entry_t     entry_o
);
  import mts_pkg::*;

  entry_t entry_d, entry_q;

  // push shifts entries away from the top, pop shifts them toward it
  always_comb begin
    if (ctrl_i.push) begin
      entry_d = up_i;
    end else if (ctrl_i.pop) begin
      entry_d = dn_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ bench/min_tracking_stack_tb.sv @@
`timescale 1ns / 1ps

module min_tracking_stack_tb;
  import mts_pkg::*;

  localparam int unsigned Depth = 256;
  localparam int NumRows = 20;
  localparam int RandomItems = 530;
  localparam int QuietItems = 40;
  localparam int DrainCycles = 10;

  // what one result item shows about the stack
  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] top;
    logic signed [DataW-1:0] mn;
    logic                    empty;
    logic [FillW-1:0]        fill;
  } stack_view_t;

  // one row of the directed table; the typed-in view is used when pinned is set
  typedef struct packed {
    logic                    req;
    logic signed [DataW-1:0] val;
    logic                    pinned;
    stack_view_t             view;
  } dir_row_t;

  localparam stack_view_t NoView = '0;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    req_type_i = REQ_PUSH;
  logic signed [DataW-1:0] push_value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [1:0]              status_o;
  logic signed [DataW-1:0] top_value_o;
  logic signed [DataW-1:0] min_value_o;
  logic                    is_empty_o;
  logic [FillW-1:0]        fill_count_o;

  // shadow copy of the stack contents
  logic signed [DataW-1:0] shadow_vals [Depth];
  logic signed [DataW-1:0] shadow_mins [Depth];
  int unsigned             shadow_count = 0;

  stack_view_t expected_views [$];
  dir_row_t    dir_rows [NumRows];

  logic    quiet = 1'b0;
  status_e last_status = ST_OK;
  int      mismatches = 0;
  int      num_results = 0;
  int      num_pushes = 0;
  int      num_pops = 0;
  int      num_full_drops = 0;
  int      num_empty_pops = 0;
  int      peak_fill = 0;
  int      stall_left = 0;

  min_tracking_stack #(
    .STACK_DEPTH(Depth)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .push_value_i(push_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .top_value_o (top_value_o),
    .min_value_o (min_value_o),
    .is_empty_o  (is_empty_o),
    .fill_count_o(fill_count_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // apply one request to the shadow stack and return the view after it
  function automatic stack_view_t apply_request(input logic req,
                                                input logic signed [DataW-1:0] val);
    stack_view_t             v;
    logic signed [DataW-1:0] new_min;
    v = NoView;
    v.status = ST_OK;
    if (req == REQ_PUSH) begin
      if (shadow_count >= Depth) begin
        v.status = ST_PUSH_FULL;
      end else begin
        new_min = val;
        if (shadow_count > 0 && shadow_mins[shadow_count-1] < val) begin
          new_min = shadow_mins[shadow_count-1];
        end
        shadow_vals[shadow_count] = val;
        shadow_mins[shadow_count] = new_min;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        v.status = ST_POP_EMPTY;
      end else begin
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      v.top = shadow_vals[shadow_count-1];
      v.mn  = shadow_mins[shadow_count-1];
    end
    v.empty = (shadow_count == 0);
    v.fill  = FillW'(shadow_count);
    return v;
  endfunction

  // append one expected view at the tail of the queue
  function automatic void expect_view(input stack_view_t v);
    expected_views.insert(expected_views.size(), v);
  endfunction

  // push values lean on the extremes and on small numbers so equal minimums come up
  function automatic logic signed [DataW-1:0] pick_value();
    logic signed [DataW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'sh7fffffff;
      1: v = 32'sh80000000;
      2: v = $signed(DataW'($urandom_range(0, 8))) - 32'sd4;
      3, 4: v = $signed(DataW'($urandom_range(0, 200))) - 32'sd100;
      default: v = $signed($urandom);
    endcase
    return v;
  endfunction

  // offer one item, wait for the handshake, record what should come back
  task automatic send_request(input logic req, input logic signed [DataW-1:0] val,
                              input logic pinned, input stack_view_t pinned_view);
    stack_view_t pred;
    int          gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    push_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_request(req, val);
    expect_view(pinned ? pinned_view : pred);
    last_status = pred.status;
    if (req == REQ_PUSH) num_pushes++;
    else num_pops++;
    if (pred.status == ST_PUSH_FULL) num_full_drops++;
    if (pred.status == ST_POP_EMPTY) num_empty_pops++;
    if (int'(shadow_count) > peak_fill) peak_fill = int'(shadow_count);
  endtask

  // hold the sender off until every outstanding result has been seen
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
  endtask

  function automatic void note_mismatch(input string field, input longint exp_v,
                                        input longint got_v);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    end
  endfunction

  // result side: compare each item, stall in random bursts
  always @(posedge clk_i) begin
    stack_view_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      num_results++;
      if (expected_views.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item, status %0d top %0d", $time, status_o,
                 top_value_o);
      end else begin
        exp_v = expected_views.pop_front();
        if (status_o !== exp_v.status) note_mismatch("status", exp_v.status, status_o);
        if (top_value_o !== exp_v.top) note_mismatch("top_value", exp_v.top, top_value_o);
        if (min_value_o !== exp_v.mn) note_mismatch("min_value", exp_v.mn, min_value_o);
        if (is_empty_o !== exp_v.empty) note_mismatch("is_empty", exp_v.empty, is_empty_o);
        if (fill_count_o !== exp_v.fill) note_mismatch("fill_count", exp_v.fill,
                                                       fill_count_o);
      end
    end
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // run limit
  initial begin
    #1_000_000;
    $display("min_tracking_stack_tb failed");
    $finish;
  end

  // stimulus
  initial begin
    int               full_hits;
    int               empty_hits;
    int               balanced_n;
    logic             req;

    // empty-stack reads, extremes, equal minimums, drain back to empty
    dir_rows = '{
      '{REQ_POP,  32'sd0,         1'b1, '{ST_POP_EMPTY, 32'sd0, 32'sd0, 1'b1, 9'd0}},
      '{REQ_PUSH, 32'sh7fffffff,  1'b1,
        '{ST_OK, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 9'd1}},
      '{REQ_PUSH, 32'sh80000000,  1'b1,
        '{ST_OK, 32'sh80000000, 32'sh80000000, 1'b0, 9'd2}},
      '{REQ_PUSH, 32'sd0,         1'b0, NoView},
      '{REQ_PUSH, 32'sh80000000,  1'b0, NoView},
      '{REQ_PUSH, -32'sd1,        1'b0, NoView},
      '{REQ_PUSH, 32'sd1,         1'b0, NoView},
      '{REQ_POP,  32'sd0,         1'b0, NoView},
      '{REQ_POP,  32'sd0,         1'b0, NoView},
      '{REQ_POP,  32'sd0,         1'b0, NoView},
      '{REQ_POP,  32'sd0,         1'b0, NoView},
      '{REQ_POP,  32'sd0,         1'b0, NoView},
      '{REQ_POP,  32'sd0,         1'b1, '{ST_OK, 32'sd0, 32'sd0, 1'b1, 9'd0}},
      '{REQ_POP,  -32'sd1,        1'b1, '{ST_POP_EMPTY, 32'sd0, 32'sd0, 1'b1, 9'd0}},
      '{REQ_PUSH, 32'sd5,         1'b0, NoView},
      '{REQ_PUSH, 32'sd5,         1'b0, NoView},
      '{REQ_PUSH, 32'sd3,         1'b0, NoView},
      '{REQ_POP,  32'sh7fffffff,  1'b0, NoView},
      '{REQ_POP,  32'sd0,         1'b0, NoView},
      '{REQ_POP,  32'sd0,         1'b1, '{ST_OK, 32'sd0, 32'sd0, 1'b1, 9'd0}}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].val, dir_rows[i].pinned,
                   dir_rows[i].view);
    end

    // climb: mostly pushes until the stack has refused several pushes while full
    full_hits = 0;
    while (full_hits < 6) begin
      req = ($urandom_range(0, 31) == 0) ? REQ_POP : REQ_PUSH;
      send_request(req, pick_value(), 1'b0, NoView);
      if (last_status == ST_PUSH_FULL) full_hits++;
    end
    wait_results_drained();

    // drain: mostly pops until several pops have hit the empty stack
    empty_hits = 0;
    while (empty_hits < 4) begin
      req = ($urandom_range(0, 31) == 0) ? REQ_PUSH : REQ_POP;
      send_request(req, pick_value(), 1'b0, NoView);
      if (last_status == ST_POP_EMPTY) empty_hits++;
    end

    // balanced mix, the tail without any idling
    balanced_n = RandomItems - (num_pushes + num_pops - NumRows);
    if (balanced_n < QuietItems) balanced_n = QuietItems;
    for (int i = 0; i < balanced_n; i++) begin
      if (i == balanced_n - QuietItems) quiet = 1'b1;
      req = ($urandom_range(0, 1) == 0) ? REQ_PUSH : REQ_POP;
      send_request(req, pick_value(), 1'b0, NoView);
    end

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d pushes and %0d pops, peak fill %0d of %0d", num_pushes,
             num_pops, peak_fill, Depth);
    $display("%0d pushes dropped on full, %0d pops on empty, %0d results checked",
             num_full_drops, num_empty_pops, num_results);
    if (mismatches == 0) begin
      $display("min_tracking_stack_tb passed");
    end else begin
      $display("min_tracking_stack_tb failed");
    end
    $finish;
  end

endmodule
